// ===== hw/rtl/tls_pkg.sv =====
// shared codes, field widths and types of the three-level thread scheduler
`default_nettype none

package tls_pkg;

  // fixed field widths of the stream items
  localparam int CMD_W      = 2;
  localparam int PRIO_W     = 2;
  localparam int STATUS_W   = 3;
  localparam int FIELD_ID_W = 8;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 24;

  // command codes carried in in_tuser
  typedef enum logic [CMD_W-1:0] {
    CMD_MAKE_READY = 2'd0,
    CMD_JOIN_WAIT  = 2'd1,
    CMD_FINISH     = 2'd2,
    CMD_DISPATCH   = 2'd3
  } cmd_t;

  // priority levels
  localparam logic [PRIO_W-1:0] PRIO_HIGH = 2'd0;
  localparam logic [PRIO_W-1:0] PRIO_MID  = 2'd1;
  localparam logic [PRIO_W-1:0] PRIO_LOW  = 2'd2;
  localparam logic [PRIO_W-1:0] PRIO_BAD  = 2'd3;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK           = 3'd0,
    ST_QUEUE_FULL   = 3'd1,
    ST_BAD_PRIO     = 3'd2,
    ST_NONE_RUNNING = 3'd3,
    ST_JOIN_FULL    = 3'd4,
    ST_NONE_READY   = 3'd5
  } status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tls_ram.sv =====
// simple dual-port synchronous ram, one write and one registered read per cycle
`default_nettype none

module tls_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = 4
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [DATA_W-1:0] wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/tls_ctrl.sv =====
// command sequencer: queue pointers, running slot, join table walk and result register
`default_nettype none

module tls_ctrl #(
  parameter int QUEUE_DEPTH  = 16,
  parameter int JOIN_ENTRIES = 16,
  parameter int ID_BITS      = 8,
  localparam int IDW = (ID_BITS < tls_pkg::FIELD_ID_W) ? ID_BITS : tls_pkg::FIELD_ID_W,
  localparam int QAW = $clog2(3 * QUEUE_DEPTH),
  localparam int JIW = (JOIN_ENTRIES > 1) ? $clog2(JOIN_ENTRIES) : 1,
  localparam int JDW = 2 * IDW + tls_pkg::PRIO_W
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // command stream
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [tls_pkg::IN_DATA_W-1:0]   in_tdata,
  input  wire logic [tls_pkg::CMD_W-1:0]       in_tuser,
  // result stream
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic      [tls_pkg::OUT_DATA_W-1:0]  out_tdata,
  // ready queue ram
  output logic                                 q_we,
  output logic      [QAW-1:0]                  q_waddr,
  output logic      [IDW-1:0]                  q_wdata,
  output logic      [QAW-1:0]                  q_raddr,
  input  wire logic [IDW-1:0]                  q_rdata,
  // join table ram
  output logic                                 j_we,
  output logic      [JIW-1:0]                  j_waddr,
  output logic      [JDW-1:0]                  j_wdata,
  output logic      [JIW-1:0]                  j_raddr,
  input  wire logic [JDW-1:0]                  j_rdata
);

  import tls_pkg::*;

  localparam int QIW = $clog2(QUEUE_DEPTH);
  localparam int QCW = $clog2(QUEUE_DEPTH + 1);
  localparam int JCW = $clog2(JOIN_ENTRIES + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_SHIFT,
    S_POP,
    S_POP_WAIT,
    S_EMIT
  } state_t;

  state_t              state_r;
  cmd_t                cmd_r;
  logic [IDW-1:0]      tid_r;
  logic [PRIO_W-1:0]   prio_r;
  logic [IDW-1:0]      target_r;
  logic [IDW-1:0]      done_r;
  status_t             status_r;
  logic                woke_r;
  logic [IDW-1:0]      woke_id_r;
  logic                run_valid_r;
  logic [IDW-1:0]      run_id_r;
  logic [QIW-1:0]      head_r  [3];
  logic [QCW-1:0]      count_r [3];
  logic [JCW-1:0]      jc_r;
  logic [JIW-1:0]      chk_r;
  logic [JIW-1:0]      mv_r;
  logic                out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  // join entry fields, packed as {target, waiter, prio}
  logic [PRIO_W-1:0]   ent_prio;
  logic [IDW-1:0]      ent_waiter;
  logic [IDW-1:0]      ent_target;
  logic                ent_match;
  logic                scan_last;
  logic                shift_last;

  // push side
  logic [PRIO_W-1:0]   push_lvl;
  logic                push_full;
  logic [QIW-1:0]      push_tail;
  logic [QCW:0]        tail_sum;
  logic [QAW-1:0]      push_addr;

  // pop side
  logic [PRIO_W-1:0]   best_lvl;
  logic                any_ready;
  logic [QIW-1:0]      pop_head;
  logic [QAW-1:0]      pop_addr;

  assign ent_prio   = j_rdata[PRIO_W-1:0];
  assign ent_waiter = j_rdata[IDW+PRIO_W-1:PRIO_W];
  assign ent_target = j_rdata[JDW-1:IDW+PRIO_W];
  assign ent_match  = (ent_target == done_r);
  assign scan_last  = (JCW'(chk_r) == jc_r - JCW'(1));
  assign shift_last = (JCW'(mv_r) == jc_r - JCW'(1));

  // tail slot and fullness of the queue being appended to
  always_comb begin
    push_lvl = (state_r == S_SCAN) ? ent_prio : prio_r;
    case (push_lvl)
      PRIO_HIGH: begin
        push_full = (count_r[0] == QCW'(QUEUE_DEPTH));
        tail_sum  = (QCW+1)'(head_r[0]) + (QCW+1)'(count_r[0]);
      end
      PRIO_MID: begin
        push_full = (count_r[1] == QCW'(QUEUE_DEPTH));
        tail_sum  = (QCW+1)'(head_r[1]) + (QCW+1)'(count_r[1]);
      end
      PRIO_LOW: begin
        push_full = (count_r[2] == QCW'(QUEUE_DEPTH));
        tail_sum  = (QCW+1)'(head_r[2]) + (QCW+1)'(count_r[2]);
      end
      default: begin
        push_full = 1'b1;
        tail_sum  = '0;
      end
    endcase
    if (tail_sum >= (QCW+1)'(QUEUE_DEPTH)) begin
      push_tail = QIW'(tail_sum - (QCW+1)'(QUEUE_DEPTH));
    end else begin
      push_tail = QIW'(tail_sum);
    end
  end

  // head of the highest non-empty queue
  always_comb begin
    any_ready = 1'b1;
    if (count_r[0] != '0) begin
      best_lvl = PRIO_HIGH;
      pop_head = head_r[0];
    end else if (count_r[1] != '0) begin
      best_lvl = PRIO_MID;
      pop_head = head_r[1];
    end else begin
      best_lvl  = PRIO_LOW;
      pop_head  = head_r[2];
      any_ready = (count_r[2] != '0);
    end
  end

  // queue ram addresses: level base plus slot
  always_comb begin
    case (push_lvl)
      PRIO_MID: push_addr = QAW'(QUEUE_DEPTH) + QAW'(push_tail);
      PRIO_LOW: push_addr = QAW'(2 * QUEUE_DEPTH) + QAW'(push_tail);
      default:  push_addr = QAW'(push_tail);
    endcase
    case (best_lvl)
      PRIO_MID: pop_addr = QAW'(QUEUE_DEPTH) + QAW'(pop_head);
      PRIO_LOW: pop_addr = QAW'(2 * QUEUE_DEPTH) + QAW'(pop_head);
      default:  pop_addr = QAW'(pop_head);
    endcase
  end

  // memory port control
  always_comb begin
    q_we    = 1'b0;
    q_waddr = push_addr;
    q_wdata = (state_r == S_SCAN) ? ent_waiter : tid_r;
    q_raddr = pop_addr;
    j_we    = 1'b0;
    j_waddr = JIW'(jc_r);
    j_wdata = {target_r, tid_r, prio_r};
    j_raddr = chk_r + JIW'(1);
    unique case (state_r)
      S_EXEC: begin
        if (cmd_r == CMD_MAKE_READY && prio_r != PRIO_BAD && !push_full) begin
          q_we = 1'b1;
        end
        if (cmd_r == CMD_JOIN_WAIT && prio_r != PRIO_BAD &&
            jc_r != JCW'(JOIN_ENTRIES)) begin
          j_we = 1'b1;
        end
        // first entry of the walk
        j_raddr = '0;
      end
      S_SCAN: begin
        if (ent_match && !push_full) begin
          q_we = 1'b1;
        end
      end
      S_SHIFT: begin
        // close the gap: entry mv+1 moves down to mv
        j_we    = !shift_last;
        j_waddr = mv_r;
        j_wdata = j_rdata;
        j_raddr = mv_r + JIW'(2);
      end
      default: begin
      end
    endcase
  end

  // sequencer and registered result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      run_valid_r <= 1'b1;
      run_id_r    <= '0;
      jc_r        <= '0;
      out_valid_r <= 1'b0;
      for (int l = 0; l < 3; l++) begin
        head_r[l]  <= '0;
        count_r[l] <= '0;
      end
    end else begin
      if (out_valid_r && out_tready && state_r != S_EMIT) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            cmd_r     <= cmd_t'(in_tuser);
            tid_r     <= in_tdata[IDW-1:0];
            prio_r    <= in_tdata[FIELD_ID_W+PRIO_W-1:FIELD_ID_W];
            target_r  <= in_tdata[FIELD_ID_W+PRIO_W+IDW-1:FIELD_ID_W+PRIO_W];
            status_r  <= ST_OK;
            woke_r    <= 1'b0;
            woke_id_r <= '0;
            state_r   <= S_EXEC;
          end
        end
        S_EXEC: begin
          unique case (cmd_r)
            CMD_MAKE_READY: begin
              state_r <= S_EMIT;
              if (prio_r == PRIO_BAD) begin
                status_r <= ST_BAD_PRIO;
              end else if (push_full) begin
                status_r <= ST_QUEUE_FULL;
              end else begin
                for (int l = 0; l < 3; l++) begin
                  if (push_lvl == PRIO_W'(l)) begin
                    count_r[l] <= count_r[l] + QCW'(1);
                  end
                end
              end
            end
            CMD_JOIN_WAIT: begin
              state_r <= S_EMIT;
              if (prio_r == PRIO_BAD) begin
                status_r <= ST_BAD_PRIO;
              end else if (jc_r == JCW'(JOIN_ENTRIES)) begin
                status_r <= ST_JOIN_FULL;
              end else begin
                jc_r <= jc_r + JCW'(1);
              end
            end
            CMD_FINISH: begin
              if (!run_valid_r) begin
                status_r <= ST_NONE_RUNNING;
                state_r  <= S_EMIT;
              end else begin
                done_r      <= run_id_r;
                run_valid_r <= 1'b0;
                run_id_r    <= '0;
                chk_r       <= '0;
                state_r     <= (jc_r == '0) ? S_POP : S_SCAN;
              end
            end
            default: begin
              // dispatch only fills an empty slot
              state_r <= run_valid_r ? S_EMIT : S_POP;
            end
          endcase
        end
        S_SCAN: begin
          // j_rdata holds entry chk_r
          if (ent_match) begin
            if (push_full) begin
              status_r <= ST_QUEUE_FULL;
              state_r  <= S_EMIT;
            end else begin
              for (int l = 0; l < 3; l++) begin
                if (push_lvl == PRIO_W'(l)) begin
                  count_r[l] <= count_r[l] + QCW'(1);
                end
              end
              woke_r    <= 1'b1;
              woke_id_r <= ent_waiter;
              mv_r      <= chk_r;
              state_r   <= S_SHIFT;
            end
          end else if (scan_last) begin
            state_r <= S_POP;
          end else begin
            chk_r <= chk_r + JIW'(1);
          end
        end
        S_SHIFT: begin
          if (shift_last) begin
            jc_r    <= jc_r - JCW'(1);
            state_r <= S_POP;
          end else begin
            mv_r <= mv_r + JIW'(1);
          end
        end
        S_POP: begin
          if (!any_ready) begin
            if (cmd_r == CMD_DISPATCH) begin
              status_r <= ST_NONE_READY;
            end
            state_r <= S_EMIT;
          end else begin
            for (int l = 0; l < 3; l++) begin
              if (best_lvl == PRIO_W'(l)) begin
                head_r[l]  <= (head_r[l] == QIW'(QUEUE_DEPTH - 1)) ? '0 :
                              head_r[l] + QIW'(1);
                count_r[l] <= count_r[l] - QCW'(1);
              end
            end
            state_r <= S_POP_WAIT;
          end
        end
        S_POP_WAIT: begin
          run_valid_r <= 1'b1;
          run_id_r    <= q_rdata;
          state_r     <= S_EMIT;
        end
        S_EMIT: begin
          if (!out_valid_r || out_tready) begin
            out_data_r  <= {3'b000, FIELD_ID_W'(woke_id_r), woke_r,
                            FIELD_ID_W'(run_id_r), run_valid_r, status_r};
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

// ===== hw/rtl/three_level_thread_scheduler_top.sv =====
// top level of the three-level strict-priority thread scheduler
//
// channel   direction  tdata (low bit up)                         tuser
// in_*      slave      thread_id[7:0] priority_req[9:8]           command[1:0]
//                      target_id[17:10] zero[23:18]
// out_*     master     status[2:0] running_valid[3] running_id[11:4] -
//                      woken_valid[12] woken_id[20:13] zero[23:21]
//
// one command at a time, a new one taken only in the idle state: make ready, join
// wait and a dispatch that finds a thread running go from execute straight to the
// result; a dispatch that finds the slot empty pops the highest non-empty queue
// and waits for the ram read, or reports none ready. finish walks the join table
// from the first entry to the first match or the end; releasing a waiter then
// moves the later entries down to close the gap, and a pop follows; a waiter
// that meets a full queue ends the finish. both walks read the ram one entry a cycle.
// reset is synchronous; the running slot holds thread zero, all queues and the
// join table are empty. a result waiting on out_tready holds the next command
// from finishing, but the next command is still accepted.
`default_nettype none

module three_level_thread_scheduler_top #(
  parameter int QUEUE_DEPTH  = 16,
  parameter int JOIN_ENTRIES = 16,
  parameter int ID_BITS      = 8
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  // thread_id, priority_req, target_id
  input  wire logic [tls_pkg::IN_DATA_W-1:0]  in_tdata,
  // command
  input  wire logic [tls_pkg::CMD_W-1:0]      in_tuser,
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  // status, running_valid, running_id, woken_valid, woken_id
  output logic      [tls_pkg::OUT_DATA_W-1:0] out_tdata
);

  import tls_pkg::*;

  localparam int IDW = (ID_BITS < FIELD_ID_W) ? ID_BITS : FIELD_ID_W;
  localparam int QAW = $clog2(3 * QUEUE_DEPTH);
  localparam int JIW = (JOIN_ENTRIES > 1) ? $clog2(JOIN_ENTRIES) : 1;
  localparam int JDW = 2 * IDW + PRIO_W;

  logic           q_we;
  logic [QAW-1:0] q_waddr;
  logic [IDW-1:0] q_wdata;
  logic [QAW-1:0] q_raddr;
  logic [IDW-1:0] q_rdata;
  logic           j_we;
  logic [JIW-1:0] j_waddr;
  logic [JDW-1:0] j_wdata;
  logic [JIW-1:0] j_raddr;
  logic [JDW-1:0] j_rdata;

  // command sequencer
  tls_ctrl #(
    .QUEUE_DEPTH  (QUEUE_DEPTH),
    .JOIN_ENTRIES (JOIN_ENTRIES),
    .ID_BITS      (ID_BITS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .q_we       (q_we),
    .q_waddr    (q_waddr),
    .q_wdata    (q_wdata),
    .q_raddr    (q_raddr),
    .q_rdata    (q_rdata),
    .j_we       (j_we),
    .j_waddr    (j_waddr),
    .j_wdata    (j_wdata),
    .j_raddr    (j_raddr),
    .j_rdata    (j_rdata)
  );

  // three ready queues, one region each
  tls_ram #(
    .DATA_W (IDW),
    .DEPTH  (3 * QUEUE_DEPTH),
    .ADDR_W (QAW)
  ) u_queue_ram (
    .clk   (clk),
    .we    (q_we),
    .waddr (q_waddr),
    .wdata (q_wdata),
    .raddr (q_raddr),
    .rdata (q_rdata)
  );

  // join waiter records in insertion order
  tls_ram #(
    .DATA_W (JDW),
    .DEPTH  (JOIN_ENTRIES),
    .ADDR_W (JIW)
  ) u_join_ram (
    .clk   (clk),
    .we    (j_we),
    .waddr (j_waddr),
    .wdata (j_wdata),
    .raddr (j_raddr),
    .rdata (j_rdata)
  );

endmodule

`default_nettype wire

// ===== tb/three_level_thread_scheduler_top_test.sv =====
// testbench of the three-level thread scheduler: directed and random commands checked against a predictor
`timescale 1ns / 1ps

module three_level_thread_scheduler_top_test;
  import tls_pkg::*;

  localparam int QDEPTH          = 16;
  localparam int JOIN_DEPTH      = 16;
  localparam int ID_POOL_MAX     = 11;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int SETTLE_CYCLES   = 64;
  localparam int WATCHDOG_LIMIT  = 5000;

  // one command item
  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] tid;
    logic [1:0] prio;
    logic [7:0] target;
  } sched_cmd_t;

  // one result item
  typedef struct packed {
    status_t    status;
    logic       running_valid;
    logic [7:0] running_id;
    logic       woken_valid;
    logic [7:0] woken_id;
  } sched_result_t;

  // one recorded join waiter
  typedef struct packed {
    logic [7:0] waiter;
    logic [7:0] target;
    logic [1:0] prio;
  } join_rec_t;

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  // thread_id, priority_req, target_id, zero pad
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  // command
  logic [CMD_W-1:0]      in_tuser = CMD_MAKE_READY;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  // status, running_valid, running_id, woken_valid, woken_id, zero pad
  logic [OUT_DATA_W-1:0] out_tdata;

  // predicted scheduler state
  logic [7:0]    high_ready[$];
  logic [7:0]    mid_ready[$];
  logic [7:0]    low_ready[$];
  join_rec_t     join_waiters[$];
  bit            sched_running = 1'b1;
  logic [7:0]    sched_running_id = '0;
  sched_result_t awaited_outcomes[$];

  int error_count   = 0;
  bit idle_on       = 1'b1;
  bit hold_off_req  = 1'b0;
  int quiet_cycles  = 0;

  three_level_thread_scheduler_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ready queue helpers of the predictor
  function automatic int ready_len(logic [1:0] level);
    case (level)
      PRIO_HIGH: return high_ready.size();
      PRIO_MID:  return mid_ready.size();
      default:   return low_ready.size();
    endcase
  endfunction

  function automatic int ready_total();
    return high_ready.size() + mid_ready.size() + low_ready.size();
  endfunction

  function automatic bit push_ready(logic [1:0] level, logic [7:0] id);
    if (ready_len(level) >= QDEPTH) return 1'b0;
    case (level)
      PRIO_HIGH: high_ready.push_back(id);
      PRIO_MID:  mid_ready.push_back(id);
      default:   low_ready.push_back(id);
    endcase
    return 1'b1;
  endfunction

  // head of the highest non-empty level
  function automatic bit pop_best(output logic [7:0] id);
    id = '0;
    if (high_ready.size() != 0) id = high_ready.pop_front();
    else if (mid_ready.size() != 0) id = mid_ready.pop_front();
    else if (low_ready.size() != 0) id = low_ready.pop_front();
    else return 1'b0;
    return 1'b1;
  endfunction

  // next state and result of one command
  function automatic sched_result_t schedule_command(sched_cmd_t c);
    sched_result_t r;
    logic [7:0]    done_id;
    logic [7:0]    next_id;
    int            hit;
    r.status      = ST_OK;
    r.woken_valid = 1'b0;
    r.woken_id    = '0;
    case (c.cmd)
      CMD_MAKE_READY: begin
        if (c.prio == PRIO_BAD) r.status = ST_BAD_PRIO;
        else if (!push_ready(c.prio, c.tid)) r.status = ST_QUEUE_FULL;
      end
      CMD_JOIN_WAIT: begin
        if (c.prio == PRIO_BAD) r.status = ST_BAD_PRIO;
        else if (join_waiters.size() >= JOIN_DEPTH) r.status = ST_JOIN_FULL;
        else join_waiters.push_back('{waiter: c.tid, target: c.target, prio: c.prio});
      end
      CMD_FINISH: begin
        if (!sched_running) begin
          r.status = ST_NONE_RUNNING;
        end else begin
          done_id          = sched_running_id;
          sched_running    = 1'b0;
          sched_running_id = '0;
          hit = -1;
          foreach (join_waiters[i]) begin
            if (hit < 0 && join_waiters[i].target == done_id) hit = i;
          end
          // first waiter on the retired thread; a full level keeps it waiting
          if (hit >= 0 && !push_ready(join_waiters[hit].prio, join_waiters[hit].waiter)) begin
            r.status = ST_QUEUE_FULL;
          end else begin
            if (hit >= 0) begin
              r.woken_valid = 1'b1;
              r.woken_id    = join_waiters[hit].waiter;
              join_waiters.delete(hit);
            end
            if (pop_best(next_id)) begin
              sched_running    = 1'b1;
              sched_running_id = next_id;
            end
          end
        end
      end
      default: begin
        if (!sched_running) begin
          if (pop_best(next_id)) begin
            sched_running    = 1'b1;
            sched_running_id = next_id;
          end else begin
            r.status = ST_NONE_READY;
          end
        end
      end
    endcase
    r.running_valid = sched_running;
    r.running_id    = sched_running ? sched_running_id : 8'd0;
    return r;
  endfunction

  // mostly small ids so joins meet running threads, sometimes any id
  function automatic logic [7:0] pick_id();
    if ($urandom_range(0, 4) == 0) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(0, ID_POOL_MAX));
  endfunction

  function automatic logic [1:0] pick_prio();
    if ($urandom_range(0, 9) == 0) return PRIO_BAD;
    return 2'($urandom_range(0, 2));
  endfunction

  // send one command item and record its expected result
  task automatic send_cmd(cmd_t cmd, logic [7:0] tid, logic [1:0] prio, logic [7:0] target);
    int         gap;
    sched_cmd_t c;
    gap = 0;
    if (idle_on && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 16);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {6'd0, target, prio, tid};
    in_tuser  <= cmd;
    do @(posedge clk); while (!in_tready);
    c.cmd    = cmd;
    c.tid    = tid;
    c.prio   = prio;
    c.target = target;
    awaited_outcomes.push_back(schedule_command(c));
  endtask

  // empty every ready level through the running slot
  task automatic drain_ready();
    while (ready_total() > 0) begin
      send_cmd(sched_running ? CMD_FINISH : CMD_DISPATCH, 8'($urandom_range(0, 255)),
               2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
    end
  endtask

  // after reset: main thread runs, then the slot empties
  task automatic test_after_reset();
    send_cmd(CMD_DISPATCH, 8'h00, PRIO_HIGH, 8'h00);
    send_cmd(CMD_FINISH, 8'hFF, PRIO_BAD, 8'hFF);
    send_cmd(CMD_FINISH, 8'h00, PRIO_HIGH, 8'h00);
    send_cmd(CMD_DISPATCH, 8'hFF, PRIO_BAD, 8'hFF);
  endtask

  // strict priority, bad priorities, join release on finish
  task automatic test_priority_order();
    send_cmd(CMD_MAKE_READY, 8'hFF, PRIO_LOW, 8'h00);
    send_cmd(CMD_MAKE_READY, 8'h00, PRIO_MID, 8'hFF);
    send_cmd(CMD_MAKE_READY, 8'hAA, PRIO_HIGH, 8'h55);
    send_cmd(CMD_MAKE_READY, 8'h12, PRIO_BAD, 8'h34);
    send_cmd(CMD_JOIN_WAIT, 8'h77, PRIO_BAD, 8'hAA);
    send_cmd(CMD_JOIN_WAIT, 8'h55, PRIO_MID, 8'hAA);
    send_cmd(CMD_JOIN_WAIT, 8'h66, PRIO_HIGH, 8'hAA);
    send_cmd(CMD_JOIN_WAIT, 8'h00, PRIO_LOW, 8'hFF);
    send_cmd(CMD_DISPATCH, 8'h00, PRIO_HIGH, 8'h00);
    send_cmd(CMD_DISPATCH, 8'h00, PRIO_HIGH, 8'h00);
    send_cmd(CMD_FINISH, 8'h00, PRIO_HIGH, 8'h00);
    send_cmd(CMD_FINISH, 8'h00, PRIO_HIGH, 8'h00);
    send_cmd(CMD_FINISH, 8'h00, PRIO_HIGH, 8'h00);
    send_cmd(CMD_FINISH, 8'h00, PRIO_HIGH, 8'h00);
    send_cmd(CMD_FINISH, 8'h00, PRIO_HIGH, 8'h00);
    send_cmd(CMD_FINISH, 8'h00, PRIO_HIGH, 8'h00);
    send_cmd(CMD_DISPATCH, 8'h00, PRIO_HIGH, 8'h00);
  endtask

  // fill each level to the brim, push once more, then drain
  task automatic test_queue_full();
    logic [1:0] levels[3];
    levels = '{PRIO_HIGH, PRIO_MID, PRIO_LOW};
    foreach (levels[k]) begin
      while (ready_len(levels[k]) < QDEPTH) begin
        send_cmd(CMD_MAKE_READY, 8'($urandom_range(0, 255)), levels[k],
                 8'($urandom_range(0, 255)));
      end
      send_cmd(CMD_MAKE_READY, 8'($urandom_range(0, 255)), levels[k],
               8'($urandom_range(0, 255)));
      drain_ready();
    end
  endtask

  // fill the join table, overflow it, then run its targets to empty it
  task automatic test_join_full();
    while (join_waiters.size() < JOIN_DEPTH) begin
      send_cmd(CMD_JOIN_WAIT, 8'($urandom_range(0, 255)), 2'($urandom_range(0, 2)),
               8'($urandom_range(0, ID_POOL_MAX)));
    end
    send_cmd(CMD_JOIN_WAIT, 8'($urandom_range(0, 255)), 2'($urandom_range(0, 2)),
             8'($urandom_range(0, ID_POOL_MAX)));
    while (join_waiters.size() > 0) begin
      send_cmd(CMD_MAKE_READY, join_waiters[0].target, PRIO_HIGH,
               8'($urandom_range(0, 255)));
      drain_ready();
    end
  endtask

  // first waiter's level full at finish: retire only, waiter kept
  task automatic test_blocked_waiter();
    logic [1:0] level;
    int         hit;
    repeat (3) begin
      if (!sched_running) begin
        send_cmd(CMD_MAKE_READY, pick_id(), 2'($urandom_range(0, 2)),
                 8'($urandom_range(0, 255)));
        send_cmd(CMD_DISPATCH, 8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)),
                 8'($urandom_range(0, 255)));
      end
      hit = -1;
      foreach (join_waiters[i]) begin
        if (hit < 0 && join_waiters[i].target == sched_running_id) hit = i;
      end
      if (hit < 0) begin
        level = 2'($urandom_range(0, 2));
        send_cmd(CMD_JOIN_WAIT, 8'($urandom_range(0, 255)), level, sched_running_id);
      end else begin
        level = join_waiters[hit].prio;
      end
      while (ready_len(level) < QDEPTH) begin
        send_cmd(CMD_MAKE_READY, 8'($urandom_range(0, 255)), level,
                 8'($urandom_range(0, 255)));
      end
      send_cmd(CMD_FINISH, 8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)),
               8'($urandom_range(0, 255)));
      drain_ready();
    end
  endtask

  // random command mix; some make-ready ids pick a waited-on target
  task automatic test_random_mix(int count);
    int         sel;
    logic [7:0] tid;
    repeat (count) begin
      sel = $urandom_range(0, 99);
      if (sel < 35) begin
        tid = pick_id();
        if (join_waiters.size() != 0 && $urandom_range(0, 4) == 0) begin
          tid = join_waiters[$urandom_range(0, join_waiters.size() - 1)].target;
        end
        send_cmd(CMD_MAKE_READY, tid, pick_prio(), 8'($urandom_range(0, 255)));
      end else if (sel < 50) begin
        send_cmd(CMD_JOIN_WAIT, pick_id(), pick_prio(),
                 ($urandom_range(0, 19) == 0) ? 8'($urandom_range(0, 255)) :
                                               8'($urandom_range(0, ID_POOL_MAX)));
      end else if (sel < 80) begin
        send_cmd(CMD_FINISH, 8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)),
                 8'($urandom_range(0, 255)));
      end else begin
        send_cmd(CMD_DISPATCH, 8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)),
                 8'($urandom_range(0, 255)));
      end
    end
  endtask

  // receiver holds off a long time while commands keep coming
  task automatic test_backpressure();
    hold_off_req = 1'b1;
    test_random_mix(60);
  endtask

  // result receiver: random ready bursts and the long hold-off
  initial begin : result_receiver
    int run_len;
    @(posedge clk);
    forever begin
      run_len = $urandom_range(1, 16);
      if (hold_off_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 2) == 0) begin
        out_tready <= 1'b0;
        repeat (run_len) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat (run_len) @(posedge clk);
      end
    end
  end

  // compare each result item with the oldest expectation
  always @(posedge clk) begin : result_check
    sched_result_t got;
    sched_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.status        = status_t'(out_tdata[2:0]);
      got.running_valid = out_tdata[3];
      got.running_id    = out_tdata[11:4];
      got.woken_valid   = out_tdata[12];
      got.woken_id      = out_tdata[20:13];
      if (awaited_outcomes.size() == 0) begin
        $error("result item with nothing expected: %h", out_tdata);
        error_count++;
      end else begin
        want = awaited_outcomes.pop_front();
        if (got.status != want.status) begin
          $error("status: expected %0d, got %0d", want.status, got.status);
          error_count++;
        end
        if (got.running_valid != want.running_valid) begin
          $error("running_valid: expected %0d, got %0d", want.running_valid, got.running_valid);
          error_count++;
        end
        if (got.running_id != want.running_id) begin
          $error("running_id: expected %0d, got %0d", want.running_id, got.running_id);
          error_count++;
        end
        if (got.woken_valid != want.woken_valid) begin
          $error("woken_valid: expected %0d, got %0d", want.woken_valid, got.woken_valid);
          error_count++;
        end
        if (got.woken_id != want.woken_id) begin
          $error("woken_id: expected %0d, got %0d", want.woken_id, got.woken_id);
          error_count++;
        end
      end
    end
  end

  // watchdog on cycles without any accepted item
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("three_level_thread_scheduler_top_test NOT OK");
        $finish;
      end
    end
  end

  // test sequence
  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_after_reset();
    test_priority_order();
    test_queue_full();
    test_join_full();
    test_blocked_waiter();
    test_backpressure();
    test_random_mix(880);
    // last stretch without idling
    idle_on = 1'b0;
    test_random_mix(150);
    in_tvalid <= 1'b0;
    while (awaited_outcomes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("three_level_thread_scheduler_top_test OK");
    end else begin
      $display("three_level_thread_scheduler_top_test NOT OK");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/tls_pkg.sv
hw/rtl/tls_ram.sv
hw/rtl/tls_ctrl.sv
hw/rtl/three_level_thread_scheduler_top.sv
tb/three_level_thread_scheduler_top_test.sv
